// ----- src/rmg_pkg.sv -----
// Shared types, codes and constants for the range map gamma table block.
package rmg_pkg;

    localparam int SAMPLE_W          = 32;
    localparam int LEVEL_W           = 8;
    localparam int QUO_W             = 8;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 2;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 32;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int INDEX_MAX         = 255;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        span_t;
    typedef logic [LEVEL_W-1:0]         level_t;
    typedef logic [QUO_W-1:0]           quo_t;
    typedef logic [OP_W-1:0]            op_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    localparam op_t OP_WRITE   = 2'd0;
    localparam op_t OP_OBSERVE = 2'd1;
    localparam op_t OP_MAP     = 2'd2;

    localparam status_t STATUS_OK         = 2'd0;
    localparam status_t STATUS_FIXED_EMPTY = 2'd1;
    localparam status_t STATUS_NO_RANGE   = 2'd2;

    localparam cfg_index_t CFG_RANGE_MODE = 2'd0;
    localparam cfg_index_t CFG_FIXED_LOW  = 2'd1;
    localparam cfg_index_t CFG_FIXED_HIGH = 2'd2;

    localparam logic    RANGE_MODE_FIXED   = 1'b0;
    localparam logic    RANGE_MODE_TRACKED = 1'b1;
    localparam sample_t FIXED_LOW_RST      = 32'sd0;
    localparam sample_t FIXED_HIGH_RST     = 32'sd65536;

endpackage

// ----- src/range_map_gamma_lut.sv -----
// Top level: window/level mapping of samples through a loadable gamma table.
//
//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+-------------------
//  in      | op, table_index, table_value, sample, frame_start | in_valid/in_ready
//  out     | level, status                                   | out_valid/out_ready
//  cfg     | cfg_index, cfg_data                             | cfg_we, no wait
//
// Table writes, observes and unused op codes finish on acceptance and leave input ready.
// A map transaction goes from accept through setup, the 8-step bit-serial divider when the
// index needs it, the registered table read and the output register; a clamped index skips
// the divider, and a bad range goes from setup straight to the output register.
// Input is ready again in the cycle after the output register loads.
// Reset clears control, tracking and configuration state; table contents stay undefined.
// A full output register holds a finished map until out_ready; a later map waits to load, and input with it.
module range_map_gamma_lut #(
    parameter int TABLE_ENTRIES = rmg_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rmg_pkg::op_t         op,
    input  logic [7:0]           table_index,
    input  rmg_pkg::level_t      table_value,
    input  rmg_pkg::sample_t     sample,
    input  logic                 frame_start,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rmg_pkg::level_t      level,
    output rmg_pkg::status_t     status,
    input  logic                 cfg_we,
    input  rmg_pkg::cfg_index_t  cfg_index,
    input  rmg_pkg::cfg_data_t   cfg_data
);
    import rmg_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam logic [ADDR_W-1:0] IDX_TOP = ADDR_W'(INDEX_MAX % TABLE_ENTRIES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    logic              range_mode_reg;
    sample_t           fixed_low_reg;
    sample_t           fixed_high_reg;

    sample_t           sample_reg;
    sample_t           lo_reg;
    sample_t           hi_reg;
    status_t           stat_reg;
    status_t           stat_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;

    logic              out_valid_reg;
    level_t            out_level_reg;
    status_t           out_status_reg;

    logic              accept;
    logic              table_we;
    logic              observe;
    logic              map_accept;
    logic              load_out;
    logic              div_start;
    logic              div_done;
    quo_t              div_quo;
    level_t            ram_rdata;

    sample_t           trk_low;
    sample_t           trk_high;
    logic              trk_seen;

    logic [SAMPLE_W:0] d_ext;
    logic [SAMPLE_W:0] r_ext;
    logic              at_or_below;
    logic              at_or_above;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign table_we   = accept && (op == OP_WRITE);
    assign observe    = accept && (op == OP_OBSERVE);
    assign map_accept = accept && (op == OP_MAP);
    assign load_out   = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_mode_reg <= RANGE_MODE_TRACKED;
            fixed_low_reg  <= FIXED_LOW_RST;
            fixed_high_reg <= FIXED_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RANGE_MODE: range_mode_reg <= cfg_data[0];
                CFG_FIXED_LOW:  fixed_low_reg  <= sample_t'(cfg_data);
                CFG_FIXED_HIGH: fixed_high_reg <= sample_t'(cfg_data);
                default:        ;
            endcase
        end
    end

    rmg_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .observe (observe),
        .restart (frame_start),
        .sample  (sample),
        .low     (trk_low),
        .high    (trk_high),
        .seen    (trk_seen)
    );

    rmg_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (table_we),
        .waddr (table_index[ADDR_W-1:0]),
        .wdata (table_value),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // range setup: offset of the sample and width of the window
    assign d_ext       = {sample_reg[SAMPLE_W-1], sample_reg} - {lo_reg[SAMPLE_W-1], lo_reg};
    assign r_ext       = {hi_reg[SAMPLE_W-1], hi_reg} - {lo_reg[SAMPLE_W-1], lo_reg};
    assign at_or_below = d_ext[SAMPLE_W] || (d_ext == '0);
    assign at_or_above = (sample_reg >= hi_reg);
    assign div_start   = (state_reg == ST_SETUP) && (stat_reg == STATUS_OK)
                         && !at_or_below && !at_or_above;

    rmg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .diff     (d_ext[SAMPLE_W-1:0]),
        .span     (r_ext[SAMPLE_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (map_accept)
                begin
                    if (range_mode_reg == RANGE_MODE_FIXED)
                    begin
                        stat_next = (fixed_low_reg >= fixed_high_reg) ? STATUS_FIXED_EMPTY
                                                                      : STATUS_OK;
                    end
                    else
                    begin
                        stat_next = trk_seen ? STATUS_OK : STATUS_NO_RANGE;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                priority if (stat_reg != STATUS_OK)
                begin
                    state_next = ST_LOAD;
                end
                else if (at_or_below)
                begin
                    idx_next   = '0;
                    state_next = ST_READ;
                end
                else if (at_or_above)
                begin
                    idx_next   = IDX_TOP;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = div_quo[ADDR_W-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        idx_reg  <= idx_next;
        if (map_accept)
        begin
            sample_reg <= sample;
            lo_reg     <= (range_mode_reg == RANGE_MODE_FIXED) ? fixed_low_reg : trk_low;
            hi_reg     <= (range_mode_reg == RANGE_MODE_FIXED) ? fixed_high_reg : trk_high;
        end
        if (load_out)
        begin
            out_level_reg  <= (stat_reg == STATUS_OK) ? ram_rdata : '0;
            out_status_reg <= stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = out_level_reg;
    assign status    = out_status_reg;

endmodule

// ----- src/rmg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rmg_tracker.sv -----
// Running minimum and maximum of observed samples.
module rmg_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            observe,
    input  logic            restart,
    input  rmg_pkg::sample_t sample,
    output rmg_pkg::sample_t low,
    output rmg_pkg::sample_t high,
    output logic            seen
);
    import rmg_pkg::*;

    sample_t low_reg;
    sample_t high_reg;
    logic    seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            seen_reg <= 1'b0;
        end
        else if (observe)
        begin
            seen_reg <= 1'b1;
            // start over on a new frame or on the very first sample
            if (restart || !seen_reg)
            begin
                low_reg  <= sample;
                high_reg <= sample;
            end
            else
            begin
                if (sample > high_reg)
                begin
                    high_reg <= sample;
                end
                if (sample < low_reg)
                begin
                    low_reg <= sample;
                end
            end
        end
    end

    assign low  = low_reg;
    assign high = high_reg;
    assign seen = seen_reg;

endmodule

// ----- src/rmg_divider.sv -----
// Bit-serial scaled divider: quotient = floor((2^QUO_W - 1) * diff / span), diff < span.
module rmg_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rmg_pkg::span_t diff,
    input  rmg_pkg::span_t span,
    output logic           done,
    output rmg_pkg::quo_t  quotient
);
    import rmg_pkg::*;

    localparam int NUM_W = SAMPLE_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SCALE = 2'd1;
    localparam logic [1:0] PH_STEP  = 2'd2;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    span_t            diff_reg;
    span_t            diff_next;
    span_t            span_reg;
    span_t            span_next;
    span_t            rem_reg;
    span_t            rem_next;
    quo_t             quo_reg;
    quo_t             quo_next;

    logic [NUM_W-1:0]    num;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W+1:0] sub;

    // 255 * diff as (diff << 8) - diff
    assign num   = {diff_reg, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, diff_reg};
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign sub   = {1'b0, trial} - {2'b00, span_reg};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        diff_next  = diff_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    diff_next  = diff;
                    span_next  = span;
                    phase_next = PH_SCALE;
                end
            end
            PH_SCALE:
            begin
                // upper bits are already below span; low bits shift in one per step
                rem_next   = num[NUM_W-1:QUO_W];
                quo_next   = num[QUO_W-1:0];
                cnt_next   = '0;
                phase_next = PH_STEP;
            end
            PH_STEP:
            begin
                if (!sub[SAMPLE_W+1])
                begin
                    rem_next = sub[SAMPLE_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SAMPLE_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- tb/sv/tb_range_map_gamma_lut.sv -----
// Self-checking testbench for range_map_gamma_lut: gamma table, range tracking and level mapping.
`timescale 1ns / 100ps

module tb_range_map_gamma_lut;
    import rmg_pkg::*;

    localparam op_t     OP_UNUSED   = 2'd3;
    localparam sample_t SAMPLE_MIN  = 32'sh8000_0000;
    localparam sample_t SAMPLE_MAX  = 32'sh7FFF_FFFF;
    localparam int      SETTLE_CYC  = 16;
    localparam int      QUIET_LIMIT = 4000;
    localparam int      PHASES      = 13;
    localparam int      PHASE_ITEMS = 128;

    typedef struct packed {
        level_t  level;
        status_t status;
    } level_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    op_t         op;
    logic [7:0]  table_index;
    level_t      table_value;
    sample_t     sample;
    logic        frame_start;
    logic        out_valid;
    logic        out_ready;
    level_t      level;
    status_t     status;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    cfg_data_t   cfg_data;

    // shadow state of the block
    level_t      gamma_shadow [TABLE_ENTRIES_DEF];
    sample_t     trk_low;
    sample_t     trk_high;
    logic        trk_seen;
    logic        mode_q;
    sample_t     fix_low_q;
    sample_t     fix_high_q;

    level_result_t expected_levels[$];

    logic steady;
    int   error_count;
    int   items_sent;
    int   maps_sent;
    int   observes_sent;
    int   writes_sent;
    int   results_checked;
    int   results_flagged;
    int   settings_used;
    int   out_hold;
    int   quiet_cycles;

    range_map_gamma_lut DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .table_index (table_index),
        .table_value (table_value),
        .sample      (sample),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .level       (level),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int draw_gap();
        if (steady)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // uniform value in [lo, hi], both inside the sample range
    function automatic sample_t pick_between(longint lo, longint hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return sample_t'(lo + longint'(r % (hi - lo + 1)));
    endfunction

    function automatic level_result_t predict_level(sample_t s);
        level_result_t r;
        longint lo;
        longint hi;
        longint idx;
        r.level  = '0;
        r.status = STATUS_OK;
        if (mode_q == RANGE_MODE_FIXED)
        begin
            if (fix_low_q >= fix_high_q)
            begin
                r.status = STATUS_FIXED_EMPTY;
                return r;
            end
            lo = fix_low_q;
            hi = fix_high_q;
        end
        else
        begin
            if (!trk_seen)
            begin
                r.status = STATUS_NO_RANGE;
                return r;
            end
            lo = trk_low;
            hi = trk_high;
        end
        if (longint'(s) <= lo)
            idx = 0;
        else if (longint'(s) >= hi)
            idx = INDEX_MAX;
        else
            idx = ((longint'(s) - lo) * INDEX_MAX) / (hi - lo);
        r.level = gamma_shadow[idx];
        return r;
    endfunction

    function automatic void absorb_item(op_t o, logic [7:0] ti, level_t tv, sample_t s,
                                        logic fs);
        case (o)
            OP_WRITE:
            begin
                gamma_shadow[ti] = tv;
                writes_sent++;
            end
            OP_OBSERVE:
            begin
                observes_sent++;
                if (fs || !trk_seen)
                begin
                    trk_low  = s;
                    trk_high = s;
                    trk_seen = 1'b1;
                end
                else
                begin
                    if (s > trk_high)
                        trk_high = s;
                    if (s < trk_low)
                        trk_low = s;
                end
            end
            OP_MAP:
            begin
                maps_sent++;
                expected_levels.push_back(predict_level(s));
            end
            default: ;
        endcase
        items_sent++;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // valid stays high across back-to-back transactions; only a gap or wait_idle lowers it
    task automatic send_item(input op_t o, input logic [7:0] ti, input level_t tv,
                             input sample_t s, input logic fs);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        table_index <= ti;
        table_value <= tv;
        sample      <= s;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_item(o, ti, tv, s, fs);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_levels.size() != 0)
            @(posedge clk);
        // let trailing writes and observes retire
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_config(input logic mode, input sample_t low, input sample_t high);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_MODE;
        cfg_data  <= cfg_data_t'(mode);
        @(posedge clk);
        cfg_index <= CFG_FIXED_LOW;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= CFG_FIXED_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        cfg_we     <= 1'b0;
        mode_q     = mode;
        fix_low_q  = low;
        fix_high_q = high;
        settings_used++;
    endtask

    task automatic test_no_tracked_range();
        send_item(OP_MAP, 8'h00, 8'h00, SAMPLE_MIN, 1'b0);
        // unused op code must not start tracking
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 32'sd1234, 1'b1);
        send_item(OP_MAP, 8'hFF, 8'hFF, SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_table_load();
        int i;
        for (i = 0; i < TABLE_ENTRIES_DEF; i++)
            send_item(OP_WRITE, 8'(i), level_t'($urandom), sample_t'($urandom),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic test_fixed_range();
        wait_idle();
        set_config(RANGE_MODE_FIXED, FIXED_LOW_RST, FIXED_HIGH_RST);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd0, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, -32'sd1, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd1, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd32768, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd65535, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd65536, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, SAMPLE_MIN, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, SAMPLE_MAX, 1'b0);
        wait_idle();
        set_config(RANGE_MODE_FIXED, SAMPLE_MIN, SAMPLE_MAX);
        send_item(OP_MAP, 8'h00, 8'h00, SAMPLE_MIN + 32'sd1, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, SAMPLE_MAX - 32'sd1, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd0, 1'b0);
        // empty fixed range: equal bounds, then reversed bounds
        wait_idle();
        set_config(RANGE_MODE_FIXED, 32'sd5, 32'sd5);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd5, 1'b0);
        wait_idle();
        set_config(RANGE_MODE_FIXED, SAMPLE_MAX, SAMPLE_MIN);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd0, 1'b0);
    endtask

    task automatic test_tracked_range();
        wait_idle();
        set_config(RANGE_MODE_TRACKED, FIXED_LOW_RST, FIXED_HIGH_RST);
        // first observe starts tracking without frame_start; range is a single point
        send_item(OP_OBSERVE, 8'h00, 8'h00, 32'sd100, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd100, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd101, 1'b0);
        send_item(OP_OBSERVE, 8'h00, 8'h00, -32'sd300, 1'b0);
        send_item(OP_OBSERVE, 8'h00, 8'h00, 32'sd700, 1'b0);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd200, 1'b0);
        send_item(OP_UNUSED, 8'h00, 8'h00, 32'sd5000, 1'b1);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd699, 1'b0);
        send_item(OP_OBSERVE, 8'h00, 8'h00, 32'sd10, 1'b1);
        send_item(OP_MAP, 8'h00, 8'h00, 32'sd9, 1'b0);
    endtask

    task automatic test_random_traffic();
        int      phase;
        int      n;
        int      kind;
        longint  lo_b;
        longint  hi_b;
        longint  obs_lo;
        longint  obs_span;
        longint  win;
        sample_t low;
        sample_t high;
        sample_t s;
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0: set_config(RANGE_MODE_FIXED, SAMPLE_MIN, SAMPLE_MAX);
                1: set_config(RANGE_MODE_TRACKED, SAMPLE_MAX, SAMPLE_MIN);
                2: set_config(RANGE_MODE_FIXED, SAMPLE_MAX, SAMPLE_MIN);
                default:
                begin
                    low = pick_between(SAMPLE_MIN, SAMPLE_MAX);
                    case ($urandom_range(0, 7))
                        0: high = low;
                        1: high = sample_t'($urandom);
                        default:
                        begin
                            win  = (longint'(1) << $urandom_range(0, 32)) - 1;
                            hi_b = longint'(low) + win;
                            high = (hi_b > SAMPLE_MAX) ? SAMPLE_MAX : sample_t'(hi_b);
                        end
                    endcase
                    set_config(1'($urandom_range(0, 1)), low, high);
                end
            endcase
            steady   = (phase % 4 == 1);
            obs_span = (longint'(1) << $urandom_range(0, 32)) - 1;
            obs_lo   = pick_between(SAMPLE_MIN, longint'(SAMPLE_MAX) - obs_span);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (mode_q == RANGE_MODE_FIXED)
                begin
                    lo_b = fix_low_q;
                    hi_b = fix_high_q;
                end
                else
                begin
                    lo_b = trk_low;
                    hi_b = trk_high;
                end
                kind = $urandom_range(0, 99);
                if (kind < 45)
                begin
                    case ($urandom_range(0, 9))
                        0:       s = sample_t'($urandom);
                        1:       s = sample_t'(lo_b + $urandom_range(0, 2) - 1);
                        2:       s = sample_t'(hi_b + $urandom_range(0, 2) - 1);
                        3:       s = $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
                        default: s = (hi_b > lo_b) ? pick_between(lo_b, hi_b)
                                                   : sample_t'($urandom);
                    endcase
                    send_item(OP_MAP, 8'($urandom), level_t'($urandom), s,
                              1'($urandom_range(0, 1)));
                end
                else if (kind < 80)
                begin
                    s = ($urandom_range(0, 99) < 3) ? sample_t'($urandom)
                                                    : pick_between(obs_lo, obs_lo + obs_span);
                    send_item(OP_OBSERVE, 8'($urandom), level_t'($urandom), s,
                              1'($urandom_range(0, 99) < 4));
                end
                else if (kind < 95)
                    send_item(OP_WRITE, 8'($urandom), level_t'($urandom), sample_t'($urandom),
                              1'($urandom_range(0, 1)));
                else
                    send_item(OP_UNUSED, 8'($urandom), level_t'($urandom), sample_t'($urandom),
                              1'($urandom_range(0, 1)));
            end
        end
        steady = 1'b0;
    endtask

    // result side: random backpressure, compare each transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                    report_mismatch("result with nothing pending", level, -1);
                else
                begin
                    if (level !== expected_levels[0].level)
                        report_mismatch("level", level, expected_levels[0].level);
                    if (status !== expected_levels[0].status)
                        report_mismatch("status", status, expected_levels[0].status);
                    if (expected_levels[0].status != STATUS_OK)
                        results_flagged++;
                    void'(expected_levels.pop_front());
                end
                results_checked++;
                out_hold = draw_gap();
            end
            else if (out_hold != 0)
                out_hold--;
            out_ready <= (out_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
                $display("tb_range_map_gamma_lut: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = OP_WRITE;
        table_index     = '0;
        table_value     = '0;
        sample          = '0;
        frame_start     = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_RANGE_MODE;
        cfg_data        = '0;
        trk_low         = '0;
        trk_high        = '0;
        trk_seen        = 1'b0;
        mode_q          = RANGE_MODE_TRACKED;
        fix_low_q       = FIXED_LOW_RST;
        fix_high_q      = FIXED_HIGH_RST;
        steady          = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        maps_sent       = 0;
        observes_sent   = 0;
        writes_sent     = 0;
        results_checked = 0;
        results_flagged = 0;
        settings_used   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_tracked_range();
        test_table_load();
        test_fixed_range();
        test_tracked_range();
        test_random_traffic();
        wait_idle();

        $display("summary: %0d input transactions (%0d maps, %0d observes, %0d table writes)",
                 items_sent, maps_sent, observes_sent, writes_sent);
        $display("summary: %0d results checked, %0d flagged, %0d range settings, %0d mismatches",
                 results_checked, results_flagged, settings_used, error_count);
        if (error_count == 0)
            $display("tb_range_map_gamma_lut: PASS");
        else
            $display("tb_range_map_gamma_lut: FAIL");
        $finish;
    end

endmodule
